>>> design/daisy_chain_telegram_node_defines.svh
// Assertion macros shared by the daisy-chain telegram node modules.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef DAISY_CHAIN_TELEGRAM_NODE_DEFINES_SVH
`define DAISY_CHAIN_TELEGRAM_NODE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define DCTN_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define DCTN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/dctn_pkg.sv
// Types and constants of the daisy-chain telegram node.
// Used by every module of the block; depends on nothing.
package dctn_pkg;

    localparam int ADDR_W = 10;
    localparam int BYTE_W = 8;
    localparam int PAYLOAD_W = 6;
    localparam int PART_W = 5;

    typedef enum logic [1:0] {
        TAG_ADDR_HI = 2'b00,
        TAG_ADDR_LO = 2'b01,
        TAG_DATA    = 2'b10,
        TAG_CHECK   = 2'b11
    } tag_t;

    localparam logic OP_LINE_BYTE = 1'b0;
    localparam logic OP_SEND      = 1'b1;

    localparam logic KIND_TX      = 1'b0;
    localparam logic KIND_DELIVER = 1'b1;

    localparam logic [BYTE_W-1:0] SEND_HI_PREFIX = 8'h20;
    localparam logic [BYTE_W-1:0] SEND_LO_PREFIX = 8'h60;
    localparam logic [BYTE_W-1:0] SEND_DATA_PREFIX = 8'h80;

    typedef struct packed {
        logic                 operation;
        logic [BYTE_W-1:0]    line_byte;
        logic [PAYLOAD_W-1:0] send_value;
    } in_item_t;

    typedef struct packed {
        logic              result_kind;
        logic [BYTE_W-1:0] result_value;
        logic              last_of_run;
    } out_item_t;

    typedef struct packed {
        logic                   deliver;
        logic [3:0][BYTE_W-1:0] bytes;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

>>> design/dctn_front.sv
// Front end: takes items, keeps the telegram slots and running XOR, classifies.
// Depends on dctn_pkg; pushes jobs into the job queue.
module dctn_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  dctn_pkg::in_item_t            in_item,
    input  logic                          cfg_wr_en,
    input  logic [dctn_pkg::ADDR_W-1:0]   cfg_wr_data,
    input  dctn_pkg::q_stat_t             q_stat,
    output logic                          push,
    output dctn_pkg::job_t                push_job
);

    logic [dctn_pkg::ADDR_W-1:0] node_address_reg;
    logic [dctn_pkg::BYTE_W-1:0] slot0_reg, slot0_next;
    logic [dctn_pkg::BYTE_W-1:0] slot1_reg, slot1_next;
    logic [dctn_pkg::BYTE_W-1:0] slot2_reg, slot2_next;
    logic [dctn_pkg::BYTE_W-1:0] xor_reg, xor_next;

    logic                        accept;
    logic [dctn_pkg::BYTE_W-1:0] b;
    logic [dctn_pkg::ADDR_W-1:0] addr;
    logic                        addr_match;
    logic                        dirs_clear;
    logic [dctn_pkg::BYTE_W-1:0] t0, t1, t2;

    assign in_stall = q_stat.full;
    assign accept   = in_valid && !q_stat.full;
    assign b        = in_item.line_byte;

    assign addr       = {slot0_reg[dctn_pkg::PART_W-1:0], slot1_reg[dctn_pkg::PART_W-1:0]};
    assign addr_match = addr == node_address_reg;
    assign dirs_clear = !slot0_reg[5] && !slot1_reg[5];

    assign t0 = dctn_pkg::SEND_HI_PREFIX
              | {3'b000, node_address_reg[dctn_pkg::ADDR_W-1:dctn_pkg::PART_W]};
    assign t1 = dctn_pkg::SEND_LO_PREFIX | {3'b000, node_address_reg[dctn_pkg::PART_W-1:0]};
    assign t2 = dctn_pkg::SEND_DATA_PREFIX | {2'b00, in_item.send_value};

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        slot2_next = slot2_reg;
        xor_next   = xor_reg;
        push       = 1'b0;
        push_job   = '0;
        if (accept)
        begin
            if (in_item.operation == dctn_pkg::OP_SEND)
            begin
                push           = 1'b1;
                push_job.bytes = {t0 ^ t1 ^ t2, t2, t1, t0};
            end
            else
            begin
                unique case (dctn_pkg::tag_t'(b[7:6]))
                    dctn_pkg::TAG_ADDR_HI:
                    begin
                        slot0_next = b;
                        xor_next   = b;
                    end
                    dctn_pkg::TAG_ADDR_LO:
                    begin
                        slot1_next = b;
                        xor_next   = xor_reg ^ b;
                    end
                    dctn_pkg::TAG_DATA:
                    begin
                        slot2_next = b;
                        xor_next   = xor_reg ^ b;
                    end
                    dctn_pkg::TAG_CHECK:
                    begin
                        if (addr_match && dirs_clear)
                        begin
                            push              = xor_reg == b;
                            push_job.deliver  = 1'b1;
                            push_job.bytes[0] = {2'b00, slot2_reg[dctn_pkg::PAYLOAD_W-1:0]};
                        end
                        else
                        begin
                            push           = 1'b1;
                            push_job.bytes = {b, slot2_reg, slot1_reg, slot0_reg};
                        end
                    end
                    default:
                    begin
                        push = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_address_reg <= '0;
            slot0_reg        <= '0;
            slot1_reg        <= '0;
            slot2_reg        <= '0;
            xor_reg          <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                node_address_reg <= cfg_wr_data;
            end
            slot0_reg <= slot0_next;
            slot1_reg <= slot1_next;
            slot2_reg <= slot2_next;
            xor_reg   <= xor_next;
        end
    end

endmodule

>>> design/dctn_queue.sv
// Job queue between front and back end.
// Depends on dctn_pkg and the assertion macro header.
`include "daisy_chain_telegram_node_defines.svh"

module dctn_queue #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dctn_pkg::job_t    wr_job,
    input  logic              pop,
    output dctn_pkg::job_t    rd_job,
    output dctn_pkg::q_stat_t q_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    dctn_pkg::job_t   mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign q_stat.full  = count_reg == FULL_CNT;
    assign q_stat.empty = count_reg == '0;
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign rd_job       = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `DCTN_ASSERT_NOW(a_no_push_when_full, push, !q_stat.full, "job pushed into full queue")
    `DCTN_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= FULL_CNT, "queue count overflow")
    `DCTN_ASSERT_NEXT(a_push_fills, do_push && !do_pop, !q_stat.empty, "push left queue empty")

endmodule

>>> design/dctn_back.sv
// Back end: plays each job out as one delivery or four transmit bytes.
// Depends on dctn_pkg and the assertion macro header.
`include "daisy_chain_telegram_node_defines.svh"

module dctn_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dctn_pkg::q_stat_t    q_stat,
    input  dctn_pkg::job_t       rd_job,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output dctn_pkg::out_item_t  out_item
);

    dctn_pkg::job_t      job_reg;
    logic                job_valid_reg;
    logic [1:0]          idx_reg;
    logic                out_valid_reg;
    dctn_pkg::out_item_t out_item_reg, out_item_next;
    logic                out_free;
    logic                emit;
    logic                last_now;

    assign out_free = !out_valid_reg || !out_stall;
    assign emit     = out_free && job_valid_reg;
    assign last_now = job_reg.deliver || idx_reg == 2'd3;
    assign pop      = (!job_valid_reg || (emit && last_now)) && !q_stat.empty;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        out_item_next.result_kind  = job_reg.deliver ? dctn_pkg::KIND_DELIVER
                                                     : dctn_pkg::KIND_TX;
        out_item_next.result_value = job_reg.bytes[idx_reg];
        out_item_next.last_of_run  = last_now;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= rd_job;
        end
        if (emit)
        begin
            out_item_reg <= out_item_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_free)
            begin
                out_valid_reg <= job_valid_reg;
            end
            if (pop)
            begin
                job_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (emit)
            begin
                if (last_now)
                begin
                    job_valid_reg <= 1'b0;
                    idx_reg       <= '0;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

    `DCTN_ASSERT_NOW(a_deliver_is_last, out_valid_reg && out_item_reg.result_kind,
        out_item_reg.last_of_run, "delivery not marked last")
    `DCTN_ASSERT_NOW(a_deliver_idx, job_valid_reg && job_reg.deliver, idx_reg == 2'd0,
        "delivery job advanced past first slot")
    `DCTN_ASSERT_NOW(a_pop_not_mid_job, pop && job_valid_reg, emit && last_now,
        "job replaced before its last result")

endmodule

>>> design/daisy_chain_telegram_node.sv
// Daisy-chain telegram node: a line byte or send request enters as one item per cycle
// while the job queue has room; a checksum byte that forwards, or a send request, queues a
// job of four transmit results, a delivery whose running XOR matches queues one, and a byte
// that completes no telegram queues none. The single output register sets the sustained
// rate, one result per cycle while out_stall is low; QUEUE_DEPTH jobs buffer bursts.
// The user must write node_address through cfg_wr_en/cfg_wr_data only while idle;
// the block does not enforce this. Depends on dctn_pkg, dctn_front, dctn_queue and dctn_back.
module daisy_chain_telegram_node #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  dctn_pkg::in_item_t          in_item,
    output logic                        out_valid,
    input  logic                        out_stall,
    output dctn_pkg::out_item_t         out_item,
    input  logic                        cfg_wr_en,
    input  logic [dctn_pkg::ADDR_W-1:0] cfg_wr_data
);

    dctn_pkg::q_stat_t q_stat;
    dctn_pkg::job_t    push_job;
    dctn_pkg::job_t    rd_job;
    logic              push;
    logic              pop;

    dctn_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_item     (in_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_stat      (q_stat),
        .push        (push),
        .push_job    (push_job)
    );

    dctn_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (push_job),
        .pop    (pop),
        .rd_job (rd_job),
        .q_stat (q_stat)
    );

    dctn_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .rd_job    (rd_job),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule
